// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the page free list RTL.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/tppfl_pkg.sv -----
// Package for the two-pool page free list: defaults, codes, command and
// result types, and saturating counter helpers. No dependencies.
package tppfl_pkg;

  localparam int DEF_PAGE_BYTES      = 4096;
  localparam int DEF_HUGE_PAGE_BYTES = 2097152;
  localparam int DEF_MAX_FRAMES      = 32768;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index taken from paddr[2].
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_TOP  = 1'b1;

  localparam logic [31:0] BASE_RESET = 32'h8000_0000;
  localparam logic [31:0] TOP_RESET  = 32'h8800_0000;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  localparam logic [1:0] ACT_ALLOC_BIT = 2'b10;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_REJECT
  } tppfl_op_t;

  typedef struct packed {
    tppfl_op_t op;
    logic      huge;
  } tppfl_cmd_t;

  typedef struct packed {
    logic [31:0]        granted;
    logic [1:0]         status;
    logic signed [15:0] small_net;
    logic signed [15:0] huge_net;
  } tppfl_res_t;

  localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] CNT_MIN = 16'sh8000;

  function automatic logic signed [15:0] sat_inc(input logic signed [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'sd1;
  endfunction

  function automatic logic signed [15:0] sat_dec(input logic signed [15:0] v);
    return (v == CNT_MIN) ? v : v - 16'sd1;
  endfunction

endpackage

// ----- hw/rtl/tppfl_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; used for the frame link store.
module tppfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/tppfl_fifo.sv -----
// Small register FIFO used between front and back and at the result side.
// Standalone; no package needed.
module tppfl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/tppfl_front.sv -----
// Front end: classifies an incoming item into push, pop or reject and
// computes its frame number. Depends on tppfl_pkg.
module tppfl_front import tppfl_pkg::*; #(
  parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
  parameter int HUGE_PAGE_BYTES = DEF_HUGE_PAGE_BYTES,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES
) (
  input  logic [1:0]                    action,
  input  logic [31:0]                   address,
  input  logic [31:0]                   base_limit,
  input  logic [31:0]                   top_limit,
  output tppfl_cmd_t                    cmd,
  output logic [$clog2(MAX_FRAMES)-1:0] frame
);

  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
  localparam logic [31:0] HUGE_MASK = 32'(HUGE_PAGE_BYTES - 1);
  localparam logic [31:0] FRAME_LIM = 32'(MAX_FRAMES);

  logic        huge;
  logic        aligned;
  logic        in_range;
  logic        frame_ok;
  logic [31:0] offset;
  logic [31:0] frame_full;

  assign huge       = action[0];
  assign aligned    = ((address & (huge ? HUGE_MASK : PAGE_MASK)) == '0);
  assign in_range   = (address >= base_limit) && (address < top_limit);
  assign offset     = address - (base_limit & ~PAGE_MASK);
  assign frame_full = offset >> PAGE_SHIFT;
  assign frame_ok   = (frame_full < FRAME_LIM);
  assign frame      = frame_full[FRAME_W-1:0];

  always_comb begin
    cmd.huge = huge;
    if ((action & ACT_ALLOC_BIT) != '0) begin
      cmd.op = OP_POP;
    end else if (aligned && in_range && frame_ok) begin
      cmd.op = OP_PUSH;
    end else begin
      cmd.op = OP_REJECT;
    end
  end

endmodule

// ----- hw/rtl/tppfl_back.sv -----
// Back end: executes classified commands against the two list heads, the
// link RAM and the net counters, and emits one result per command.
// Depends on tppfl_pkg and tppfl_ram.
module tppfl_back import tppfl_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   base_limit,
  input  logic                          cmd_empty,
  input  tppfl_cmd_t                    cmd,
  input  logic [$clog2(MAX_FRAMES)-1:0] cmd_frame,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output tppfl_res_t                    res
);

  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] small_head_r, small_head_nxt;
  logic [FRAME_W-1:0] huge_head_r, huge_head_nxt;
  logic               small_vld_r, small_vld_nxt;
  logic               huge_vld_r, huge_vld_nxt;
  logic signed [15:0] small_cnt_r, small_cnt_nxt;
  logic signed [15:0] huge_cnt_r, huge_cnt_nxt;
  logic [FRAME_W-1:0] pop_frame_r, pop_frame_nxt;
  logic               pop_huge_r, pop_huge_nxt;

  logic               sel_huge;
  logic [FRAME_W-1:0] cur_head;
  logic               cur_vld;
  logic               ram_en, ram_we;
  logic [FRAME_W-1:0] ram_addr;
  logic [FRAME_W:0]   ram_wdata, ram_rdata;
  logic [31:0]        grant_addr;

  tppfl_ram #(
    .WIDTH(FRAME_W + 1),
    .DEPTH(MAX_FRAMES)
  ) u_link_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign sel_huge   = (state_r == ST_POP_WAIT) ? pop_huge_r : cmd.huge;
  assign cur_head   = sel_huge ? huge_head_r : small_head_r;
  assign cur_vld    = sel_huge ? huge_vld_r : small_vld_r;
  assign grant_addr = (base_limit & ~PAGE_MASK)
                    + ({{(32 - FRAME_W){1'b0}}, pop_frame_r} << PAGE_SHIFT);

  always_comb begin
    state_nxt      = state_r;
    small_head_nxt = small_head_r;
    huge_head_nxt  = huge_head_r;
    small_vld_nxt  = small_vld_r;
    huge_vld_nxt   = huge_vld_r;
    small_cnt_nxt  = small_cnt_r;
    huge_cnt_nxt   = huge_cnt_r;
    pop_frame_nxt  = pop_frame_r;
    pop_huge_nxt   = pop_huge_r;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = cmd_frame;
    ram_wdata      = {cur_vld, cur_head};

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              // Old head becomes the link of the new head frame.
              ram_en     = 1'b1;
              ram_we     = 1'b1;
              res_push   = 1'b1;
              res.status = STAT_OK;
              if (cmd.huge) begin
                huge_head_nxt = cmd_frame;
                huge_vld_nxt  = 1'b1;
                huge_cnt_nxt  = sat_dec(huge_cnt_r);
              end else begin
                small_head_nxt = cmd_frame;
                small_vld_nxt  = 1'b1;
                small_cnt_nxt  = sat_dec(small_cnt_r);
              end
            end
            OP_POP: begin
              if (!cur_vld) begin
                res_push   = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                ram_en        = 1'b1;
                ram_addr      = cur_head;
                pop_frame_nxt = cur_head;
                pop_huge_nxt  = cmd.huge;
                state_nxt     = ST_POP_WAIT;
              end
            end
            default: begin
              res_push   = 1'b1;
              res.status = STAT_REJECT;
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        // Link read has landed; room in the result queue was checked at issue.
        res_push    = 1'b1;
        res.status  = STAT_OK;
        res.granted = grant_addr;
        state_nxt   = ST_IDLE;
        if (pop_huge_r) begin
          huge_head_nxt = ram_rdata[FRAME_W-1:0];
          huge_vld_nxt  = ram_rdata[FRAME_W];
          huge_cnt_nxt  = sat_inc(huge_cnt_r);
        end else begin
          small_head_nxt = ram_rdata[FRAME_W-1:0];
          small_vld_nxt  = ram_rdata[FRAME_W];
          small_cnt_nxt  = sat_inc(small_cnt_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.small_net = small_cnt_nxt;
    res.huge_net  = huge_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      small_vld_r <= 1'b0;
      huge_vld_r  <= 1'b0;
      small_cnt_r <= '0;
      huge_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      small_vld_r <= small_vld_nxt;
      huge_vld_r  <= huge_vld_nxt;
      small_cnt_r <= small_cnt_nxt;
      huge_cnt_r  <= huge_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    small_head_r <= small_head_nxt;
    huge_head_r  <= huge_head_nxt;
    pop_frame_r  <= pop_frame_nxt;
    pop_huge_r   <= pop_huge_nxt;
  end

endmodule

// ----- hw/rtl/two_pool_page_free_list.sv -----
// Top level of the two-pool page free list: configuration registers, front
// end, command queue, back end and result queue.
// Depends on tppfl_pkg, tppfl_front, tppfl_fifo, tppfl_back and assert_macros.svh.
// Usage: items enter through a queue-style port (in_push/in_full) with an action
// (free small, free huge, alloc small, alloc huge) and an address. Each item gives
// one result on the out_ port, taken with out_pop while out_empty is low: the
// granted address, a status code and the two saturating net counters after it.
// The front end classifies an item in the cycle of its transfer and writes it
// into a two-entry command queue; the back end takes one command at a time.
// A free, a rejected item or an allocation from an empty list is finished in
// the idle state. An allocation from a non-empty list also passes the pop-wait
// state, since the head frame's link comes from the link RAM through a
// registered read before the head can move on.
// If the receiver stops popping, the two-entry result queue fills, the back end
// stalls, the command queue fills and in_full rises; nothing is dropped.
// Reset empties both lists, zeroes the counters and loads the default limits.
// The link RAM needs no clearing pass, since a frame's link is written when it
// is pushed, before it can ever be read. The APB-style port holds base_limit at
// byte address 0 and top_limit at 4.
`include "assert_macros.svh"

module two_pool_page_free_list import tppfl_pkg::*; #(
  parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
  parameter int HUGE_PAGE_BYTES = DEF_HUGE_PAGE_BYTES,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input queue port.
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_action,
  input  logic [31:0]           in_address,
  // Result queue port.
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [31:0]           out_granted_address,
  output logic [1:0]            out_status,
  output logic signed [15:0]    out_small_net,
  output logic signed [15:0]    out_huge_net,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int CMD_BITS = $bits(tppfl_cmd_t);
  localparam int CMD_W    = FRAME_W + CMD_BITS;
  localparam int RES_W    = $bits(tppfl_res_t);
  localparam int Q_DEPTH  = 2;

  logic [31:0]        base_limit_r;
  logic [31:0]        top_limit_r;
  logic               cfg_wr;

  tppfl_cmd_t         front_cmd;
  logic [FRAME_W-1:0] front_frame;
  logic [CMD_W-1:0]   cmd_q;
  logic               cmd_empty;
  logic               cmd_pop;
  tppfl_cmd_t         back_cmd;
  logic [FRAME_W-1:0] back_frame;

  tppfl_res_t         res;
  logic               res_push;
  logic               res_full;
  logic [RES_W-1:0]   res_q;
  tppfl_res_t         res_head;
  logic               fail_result;

  // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_limit_r <= BASE_RESET;
      top_limit_r  <= TOP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE) begin
        base_limit_r <= pwdata;
      end else begin
        top_limit_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_TOP) ? top_limit_r : base_limit_r;

  // Front end: classify the item as it is transferred in.
  tppfl_front #(
    .PAGE_BYTES     (PAGE_BYTES),
    .HUGE_PAGE_BYTES(HUGE_PAGE_BYTES),
    .MAX_FRAMES     (MAX_FRAMES)
  ) u_front (
    .action    (in_action),
    .address   (in_address),
    .base_limit(base_limit_r),
    .top_limit (top_limit_r),
    .cmd       (front_cmd),
    .frame     (front_frame)
  );

  // Command queue decouples the front end from the back end.
  tppfl_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(Q_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata({front_frame, front_cmd}),
    .pop  (cmd_pop),
    .rdata(cmd_q),
    .full (in_full),
    .empty(cmd_empty)
  );

  assign back_cmd   = tppfl_cmd_t'(cmd_q[CMD_BITS-1:0]);
  assign back_frame = cmd_q[CMD_W-1:CMD_BITS];

  // Back end: list heads, link RAM and counters.
  tppfl_back #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_limit(base_limit_r),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_frame (back_frame),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue lets the back end keep working while a result waits.
  tppfl_fifo #(
    .WIDTH(RES_W),
    .DEPTH(Q_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .pop  (out_pop),
    .rdata(res_q),
    .full (res_full),
    .empty(out_empty)
  );

  assign res_head            = tppfl_res_t'(res_q);
  assign out_granted_address = res_head.granted;
  assign out_status          = res_head.status;
  assign out_small_net       = res_head.small_net;
  assign out_huge_net        = res_head.huge_net;

  assign fail_result = (out_status == STAT_EMPTY) || (out_status == STAT_REJECT);

  // The back end only takes a command that is really there.
  `ASSERT_IMPLY(a_cmd_pop_valid, clk, rst_n, cmd_pop, !cmd_empty)
  // Room for a granted allocation is reserved when its read is issued.
  `ASSERT_IMPLY(a_res_room, clk, rst_n, res_push, !res_full)
  // A result written by the back end is visible on the next cycle.
  `ASSERT_NEXT(a_res_visible, clk, rst_n, res_push, !out_empty)
  // Empty allocations and rejected frees never carry an address.
  `ASSERT_IMPLY(a_no_grant_on_fail, clk, rst_n, !out_empty && fail_result, out_granted_address == '0)

endmodule

// ----- verif/two_pool_page_free_list_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for two_pool_page_free_list: a scoreboard class predicts
// every result while plain tasks drive the queue ports and the APB-style registers.
// Depends on tppfl_pkg and the two_pool_page_free_list RTL.

module two_pool_page_free_list_tb;
  import tppfl_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int NUM_PHASES = 7;
  localparam int POOL_SMALL = 0;
  localparam int POOL_HUGE = 1;
  localparam logic [31:0] PAGE_SZ = DEF_PAGE_BYTES;
  localparam logic [31:0] HUGE_SZ = DEF_HUGE_PAGE_BYTES;
  localparam logic [31:0] FRAME_CNT = DEF_MAX_FRAMES;

  // Action codes as the input port encodes them.
  typedef enum logic [1:0] {
    ACT_FREE_SMALL,
    ACT_FREE_HUGE,
    ACT_ALLOC_SMALL,
    ACT_ALLOC_HUGE
  } page_act_e;

  // The scoreboard keeps its own copy of both free lists, the link memory, the
  // net counters and the two limits. Every accepted input is applied to that copy
  // at once, and the result it yields waits in grants_due until the block's own
  // result for the same item is popped.
  class page_pool_scoreboard;
    logic [31:0] base_lim;
    logic [31:0] top_lim;
    logic [15:0] link_next [DEF_MAX_FRAMES];
    bit link_live [DEF_MAX_FRAMES];
    logic [15:0] head [2];
    bit head_live [2];
    logic signed [15:0] pool_net [2];
    tppfl_res_t grants_due [$];
    int errors;

    function new();
      base_lim = BASE_RESET;
      top_lim = TOP_RESET;
      foreach (link_next[i]) begin
        link_next[i] = '0;
        link_live[i] = 1'b0;
      end
      foreach (head[p]) begin
        head[p] = '0;
        head_live[p] = 1'b0;
        pool_net[p] = '0;
      end
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_BASE) base_lim = value;
      else top_lim = value;
    endfunction

    function logic signed [15:0] saturate(logic signed [15:0] v, int delta);
      int t;
      t = int'(v) + delta;
      if (t > int'(CNT_MAX)) t = int'(CNT_MAX);
      if (t < int'(CNT_MIN)) t = int'(CNT_MIN);
      return t[15:0];
    endfunction

    // Frame numbers count pages up from the base limit rounded down to a page.
    function tppfl_res_t apply_page_op(page_act_e act, logic [31:0] addr);
      tppfl_res_t r;
      int p;
      logic [31:0] origin;
      logic [31:0] frame;
      logic [31:0] align;
      bit ok;
      p = (act == ACT_FREE_HUGE || act == ACT_ALLOC_HUGE) ? POOL_HUGE : POOL_SMALL;
      origin = base_lim - (base_lim % PAGE_SZ);
      r.granted = '0;
      r.status = STAT_OK;
      if (act == ACT_FREE_SMALL || act == ACT_FREE_HUGE) begin
        align = (p == POOL_HUGE) ? HUGE_SZ : PAGE_SZ;
        ok = (addr % align == 0) && addr >= base_lim && addr < top_lim;
        frame = (addr - origin) / PAGE_SZ;
        if (!ok || frame >= FRAME_CNT) begin
          r.status = STAT_REJECT;
        end else begin
          link_next[frame] = head[p];
          link_live[frame] = head_live[p];
          head[p] = frame[15:0];
          head_live[p] = 1'b1;
          pool_net[p] = saturate(pool_net[p], -1);
        end
      end else if (!head_live[p]) begin
        r.status = STAT_EMPTY;
      end else begin
        frame = head[p] % FRAME_CNT;
        r.granted = origin + frame * PAGE_SZ;
        head[p] = link_next[frame];
        head_live[p] = link_live[frame];
        pool_net[p] = saturate(pool_net[p], 1);
      end
      r.small_net = pool_net[POOL_SMALL];
      r.huge_net = pool_net[POOL_HUGE];
      return r;
    endfunction

    function void note_input(page_act_e act, logic [31:0] addr);
      grants_due.push_back(apply_page_op(act, addr));
    endfunction

    function void check_result(tppfl_res_t got);
      tppfl_res_t want;
      if (grants_due.size() == 0) begin
        flag($sformatf("result with nothing expected: addr %h status %0d",
                       got.granted, got.status));
        return;
      end
      want = grants_due.pop_front();
      if (got.granted !== want.granted || got.status !== want.status ||
          got.small_net !== want.small_net || got.huge_net !== want.huge_net)
        flag($sformatf("expected addr %h st %0d small %0d huge %0d, got %h %0d %0d %0d",
                       want.granted, want.status, want.small_net, want.huge_net,
                       got.granted, got.status, got.small_net, got.huge_net));
    endfunction

    function int outstanding();
      return grants_due.size();
    endfunction

    function void flag_leftovers();
      if (grants_due.size() != 0)
        flag($sformatf("%0d results never arrived", grants_due.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_action = '0;
  logic [31:0] in_address = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [31:0] out_granted_address;
  logic [1:0] out_status;
  logic signed [15:0] out_small_net;
  logic signed [15:0] out_huge_net;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  page_pool_scoreboard sb = new();

  // Idling knobs. The sender's is read only by the stimulus process; the
  // receiver's and the hold-off request are handed over with nonblocking writes.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int random_sent = 0;
  int unsigned cycle_count = 0;
  logic [31:0] recent_frees [$];

  // Limit settings for the random phases: the defaults, the full address space,
  // a high unaligned base near the top of memory, a small unaligned window, an
  // empty window, an inverted pair at the extremes and a window exactly as large
  // as the frame range.
  logic [31:0] phase_base [NUM_PHASES] = '{32'h8000_0000, 32'h0000_0000, 32'hFFF0_0123,
                                           32'h1234_5678, 32'h4000_0000, 32'hFFFF_FFFF,
                                           32'h0000_0000};
  logic [31:0] phase_top [NUM_PHASES] = '{32'h8800_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'h1300_0000, 32'h4000_0000, 32'h0000_0000,
                                          32'h0800_0000};

  two_pool_page_free_list dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_action           (in_action),
    .in_address          (in_address),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .out_small_net       (out_small_net),
    .out_huge_net        (out_huge_net),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // A stuck handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before any of this edge's
  // updates land, so a transfer is seen exactly as the block sees it. After the
  // check the next pop value is chosen: a long hold-off when the stimulus asks
  // for one, counted down here, otherwise a random stall at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty)
        sb.check_result(tppfl_res_t'({out_granted_address, out_status,
                                      out_small_net, out_huge_net}));
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct = 54;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct <= 54;
      end
      default: begin
        send_idle_pct = 35;
        recv_stall_pct <= 35;
      end
    endcase
  endtask

  // Offers one item and returns at the edge of its transfer. in_push stays high
  // so that the next item can follow without a gap.
  task automatic offer(input page_act_e act, input logic [31:0] addr);
    in_push <= 1'b1;
    in_action <= act;
    in_address <= addr;
    do @(posedge clk); while (in_full);
    sb.note_input(act, addr);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Waits until every expected result has come back, then lets the pipeline
  // settle. settle must be at least one so that no drive lands twice in a step.
  task automatic wait_drained(input int settle);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic read_check(input logic idx);
    logic [31:0] want;
    want = (idx == REG_BASE) ? sb.base_lim : sb.top_lim;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.flag($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Limits change only with the block idle. Every item yields a result, so
  // once the last one is back a few cycles cover the deepest pipeline.
  task automatic configure(input logic [31:0] new_base, input logic [31:0] new_top);
    in_push <= 1'b0;
    wait_drained(4);
    write_reg(REG_BASE, new_base);
    write_reg(REG_TOP, new_top);
    read_check(REG_BASE);
    read_check(REG_TOP);
  endtask

  // A free address that mostly passes the checks under the current limits: a
  // random spot inside the window that has frame numbers, rounded up to its
  // pool's page size. Now and then a recent address comes back, which makes double
  // frees and frames shared by both pools.
  function automatic logic [31:0] pick_free_addr(input bit huge);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned origin;
    longint unsigned a;
    longint unsigned align;
    if (recent_frees.size() != 0 && $urandom_range(99) < 4)
      return recent_frees[$urandom_range(recent_frees.size() - 1)];
    origin = sb.base_lim - (sb.base_lim % PAGE_SZ);
    lo = sb.base_lim;
    hi = origin + longint'(FRAME_CNT) * PAGE_SZ;
    if (sb.top_lim < hi) hi = sb.top_lim;
    if (hi <= lo) return $urandom;
    align = huge ? HUGE_SZ : PAGE_SZ;
    a = lo + longint'($urandom) % (hi - lo);
    a = (a + align - 1) / align * align;
    return a[31:0];
  endfunction

  // Addresses that sit on or just past the edges of what a free accepts, or are fully random.
  function automatic logic [31:0] pick_odd_addr();
    case ($urandom_range(5))
      0: return $urandom;
      1: return pick_free_addr(1'b0) ^ (32'h1 << $urandom_range(11));
      2: return sb.base_lim - 1;
      3: return sb.top_lim;
      4: return sb.base_lim - (sb.base_lim % PAGE_SZ) + FRAME_CNT * PAGE_SZ;
      default: return pick_free_addr(1'b1) + PAGE_SZ;
    endcase
  endfunction

  // Random traffic: runs of good frees into one pool, runs of allocations from
  // one pool (long enough to empty it now and then), and single odd items with
  // any action and an address on or near the edges of the window.
  task automatic run_random(input int n);
    int left;
    int len;
    int kind;
    page_act_e act;
    logic [31:0] a;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      len = (kind < 70) ? $urandom_range(1, 12) : 1;
      if (len > left) len = left;
      act = page_act_e'($urandom_range(3));
      repeat (len) begin
        if (random_sent % 25 == 0) set_idle_mode(random_sent / 25);
        if (kind < 35) begin
          act = (act == ACT_FREE_HUGE || act == ACT_ALLOC_HUGE) ? ACT_FREE_HUGE
                                                                : ACT_FREE_SMALL;
          a = pick_free_addr(act == ACT_FREE_HUGE);
          recent_frees.push_back(a);
          if (recent_frees.size() > 16) void'(recent_frees.pop_front());
        end else if (kind < 70) begin
          act = (act == ACT_FREE_HUGE || act == ACT_ALLOC_HUGE) ? ACT_ALLOC_HUGE
                                                                : ACT_ALLOC_SMALL;
          a = $urandom;
        end else begin
          a = pick_odd_addr();
        end
        maybe_gap();
        offer(act, a);
        random_sent++;
        left--;
      end
    end
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The limits must read back as their reset values.
    read_check(REG_BASE);
    read_check(REG_TOP);

    // Directed items under the reset limits: empty lists, the first and last
    // frames, the range and alignment rejections of a free, and LIFO order on the way out.
    offer(ACT_ALLOC_SMALL, 32'hFFFF_FFFF);
    offer(ACT_ALLOC_HUGE, 32'h0000_0000);
    offer(ACT_FREE_SMALL, 32'h8000_0000);
    offer(ACT_FREE_SMALL, 32'h87FF_F000);
    offer(ACT_FREE_SMALL, 32'h8800_0000);
    offer(ACT_FREE_SMALL, 32'h7FFF_F000);
    offer(ACT_FREE_SMALL, 32'h8000_0800);
    offer(ACT_FREE_HUGE, 32'h8000_1000);
    offer(ACT_FREE_HUGE, 32'h87E0_0000);
    offer(ACT_FREE_SMALL, 32'hFFFF_FFFF);
    offer(ACT_FREE_HUGE, 32'h0000_0000);
    repeat (3) offer(ACT_ALLOC_SMALL, 32'h0);
    repeat (2) offer(ACT_ALLOC_HUGE, 32'h0);

    // A double free links the frame to itself, so the small list hands it out
    // again and again. Freeing the same frame to the empty huge list then
    // rewrites its link as end of list, which ends the loop in both pools.
    offer(ACT_FREE_SMALL, 32'h8020_0000);
    offer(ACT_FREE_SMALL, 32'h8020_0000);
    repeat (2) offer(ACT_ALLOC_SMALL, 32'h0);
    offer(ACT_FREE_HUGE, 32'h8020_0000);
    repeat (2) offer(ACT_ALLOC_SMALL, 32'h0);
    repeat (2) offer(ACT_ALLOC_HUGE, 32'h0);

    // With the whole address space open, the frame count is the only bound.
    // Moving the base while pages are listed rebuilds their addresses, here
    // with a wrap past the top of the address space.
    configure(32'h0000_0000, 32'hFFFF_FFFF);
    offer(ACT_FREE_SMALL, 32'h0800_0000);
    offer(ACT_FREE_SMALL, 32'h07FF_F000);
    offer(ACT_FREE_HUGE, 32'h07E0_0000);
    configure(32'hFFFF_0000, 32'hFFFF_FFFF);
    offer(ACT_ALLOC_SMALL, 32'h0);
    offer(ACT_ALLOC_HUGE, 32'h0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      configure(phase_base[ph], phase_top[ph]);
      if (ph == 0) begin
        // The receiver holds off while items keep coming, so both queues fill
        // and in_full must stall the sender. Then the sender waits for every
        // result before going on.
        hold_requests <= hold_requests + 1;
        repeat (24) offer(ACT_FREE_SMALL, pick_free_addr(1'b0));
        in_push <= 1'b0;
        wait_drained(2);
      end
      run_random(RANDOM_PER_PHASE);
    end

    in_push <= 1'b0;
    wait_drained(12);
    sb.flag_leftovers();
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- two_pool_page_free_list.f -----
+incdir+hw/rtl
hw/rtl/tppfl_pkg.sv
hw/rtl/tppfl_ram.sv
hw/rtl/tppfl_fifo.sv
hw/rtl/tppfl_front.sv
hw/rtl/tppfl_back.sv
hw/rtl/two_pool_page_free_list.sv
verif/two_pool_page_free_list_tb.sv
